// ----- hdl/joystick_direction_button_events_assert.svh -----
// Assertion macros for the joystick event block.
// Included by joystick_direction_button_events.sv; expects aclk and aresetn in scope.
`ifndef JOYSTICK_DIRECTION_BUTTON_EVENTS_ASSERT_SVH
`define JOYSTICK_DIRECTION_BUTTON_EVENTS_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define JDBE_ASSERT_NOW(label, cond, expect_expr, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (cond) |-> (expect_expr)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define JDBE_ASSERT_NEXT(label, cond, expect_expr, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (cond) |=> (expect_expr)) else $error(msg);

`endif

// ----- hdl/jdbe_pkg.sv -----
// Shared types and constants for the joystick direction / button event block.
// No dependencies; used by joystick_direction_button_events.sv.
package jdbe_pkg;

    // Default parameter values
    localparam int SAMPLE_BITS_DEF = 12;
    localparam int TIME_BITS_DEF   = 32;

    // Register widths (fixed)
    localparam int CENTER_W = 12;
    localparam int DZ_W     = 12;
    localparam int MS_W     = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Reset values of the configuration registers
    localparam logic [CENTER_W-1:0] CENTER_RST    = 12'd1800;
    localparam logic [DZ_W-1:0]     DEADZONE_RST  = 12'd700;
    localparam logic [MS_W-1:0]     REPEAT_RST    = 16'd250;
    localparam logic [MS_W-1:0]     DEBOUNCE_RST  = 16'd30;
    localparam logic [MS_W-1:0]     LONG_RST      = 16'd500;

    // Register indexes on the write port
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_STICK_DISABLED = 3'd0,
        CFG_CENTER_VALUE   = 3'd1,
        CFG_DEADZONE       = 3'd2,
        CFG_REPEAT_MS      = 3'd3,
        CFG_DEBOUNCE_MS    = 3'd4,
        CFG_LONG_PRESS_MS  = 3'd5
    } cfg_index_t;

    // Result codes
    localparam int EVENT_W = 3;
    typedef enum logic [EVENT_W-1:0] {
        EV_NONE  = 3'd0,
        EV_UP    = 3'd1,
        EV_DOWN  = 3'd2,
        EV_LEFT  = 3'd3,
        EV_RIGHT = 3'd4,
        EV_SHORT = 3'd5,
        EV_LONG  = 3'd6
    } event_t;

endpackage

// ----- hdl/joystick_direction_button_events.sv -----
// Top level of the joystick direction / button event block.
// Depends on jdbe_pkg.sv and joystick_direction_button_events_assert.svh.
//
// One poll per transaction on the s_ stream (two axis ADC codes, the raw
// button pin and a millisecond timestamp) gives exactly one event code on
// the m_ stream: none, up, down, left, right, short press or long press.
// Throughput is one poll per clock while m_tready is high; a poll passes
// the input register, then the result register. A poll sits in the input
// register, the decision logic reads it together with the held state and
// writes both the new state and the event code at the same edge, so the
// next poll already sees the updated state. The input register takes a poll
// whenever it is empty, or when it hands its own poll on in that same cycle;
// with both registers full and m_tready low, s_tready drops.
// Both axes are centred on center_value; the larger deviation wins (vertical
// on a tie) and must strictly exceed deadzone. A new direction reports once
// and repeats each time more than repeat_ms pass while held; a return to
// centre clears the direction silently. A poll that reports a direction
// leaves the button logic untouched. The button level must be stable for
// more than debounce_ms; release gives a short press unless a long press
// (held more than long_press_ms) was already reported. Timestamps wrap.
// stick_disabled=1 answers every poll with none and freezes all state.
// The user must write configuration via cfg_wr_en/cfg_index/cfg_data only
// while idle; not enforced. Indexes beyond the register list are ignored.
module joystick_direction_button_events #(
    parameter int SAMPLE_BITS = jdbe_pkg::SAMPLE_BITS_DEF,
    parameter int TIME_BITS   = jdbe_pkg::TIME_BITS_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    // poll input
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // [vertical_sample, horizontal_sample, button_level, now_ms, zero pad]
    input  logic [((2*SAMPLE_BITS+1+TIME_BITS+7)/8)*8-1:0] s_tdata,
    // event output
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // [event_code, zero pad]
    output logic [7:0]                         m_tdata,
    // configuration writes
    input  logic                               cfg_wr_en,
    input  logic [jdbe_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [jdbe_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int V_LO    = 0;
    localparam int H_LO    = SAMPLE_BITS;
    localparam int BTN_POS = 2*SAMPLE_BITS;
    localparam int NOW_LO  = 2*SAMPLE_BITS + 1;
    // signed deviation width: room for sample minus centre plus negation
    localparam int DEV_W = ((SAMPLE_BITS > jdbe_pkg::CENTER_W) ?
                            SAMPLE_BITS : jdbe_pkg::CENTER_W) + 2;

    // ---------------- configuration registers ----------------
    logic                           stick_disabled_reg;
    logic [jdbe_pkg::CENTER_W-1:0]  center_reg;
    logic [jdbe_pkg::DZ_W-1:0]      deadzone_reg;
    logic [jdbe_pkg::MS_W-1:0]      repeat_reg;
    logic [jdbe_pkg::MS_W-1:0]      debounce_reg;
    logic [jdbe_pkg::MS_W-1:0]      long_press_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stick_disabled_reg <= 1'b0;
            center_reg         <= jdbe_pkg::CENTER_RST;
            deadzone_reg       <= jdbe_pkg::DEADZONE_RST;
            repeat_reg         <= jdbe_pkg::REPEAT_RST;
            debounce_reg       <= jdbe_pkg::DEBOUNCE_RST;
            long_press_reg     <= jdbe_pkg::LONG_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                jdbe_pkg::CFG_STICK_DISABLED: stick_disabled_reg <= cfg_data[0];
                jdbe_pkg::CFG_CENTER_VALUE:
                    center_reg <= cfg_data[jdbe_pkg::CENTER_W-1:0];
                jdbe_pkg::CFG_DEADZONE:
                    deadzone_reg <= cfg_data[jdbe_pkg::DZ_W-1:0];
                jdbe_pkg::CFG_REPEAT_MS:     repeat_reg     <= cfg_data;
                jdbe_pkg::CFG_DEBOUNCE_MS:   debounce_reg   <= cfg_data;
                jdbe_pkg::CFG_LONG_PRESS_MS: long_press_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // ---------------- handshake / pipeline control ----------------
    logic in_valid_reg, in_valid_next;
    logic out_valid_reg, out_valid_next;
    logic advance;   // input register moves into the result register
    logic s_accept;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || !out_valid_reg || m_tready;
    assign s_accept = s_tvalid && s_tready;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_accept) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (advance) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // ---------------- input register ----------------
    logic [SAMPLE_BITS-1:0] v_sample_reg;
    logic [SAMPLE_BITS-1:0] h_sample_reg;
    logic                   button_reg;
    logic [TIME_BITS-1:0]   now_reg;

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            v_sample_reg <= s_tdata[V_LO +: SAMPLE_BITS];
            h_sample_reg <= s_tdata[H_LO +: SAMPLE_BITS];
            button_reg   <= s_tdata[BTN_POS];
            now_reg      <= s_tdata[NOW_LO +: TIME_BITS];
        end
    end

    // ---------------- direction decision ----------------
    logic signed [DEV_W-1:0] dev_v, dev_h, mag_v, mag_h, dz_pos, dz_neg;
    jdbe_pkg::event_t        dir;

    always_comb begin
        dev_v  = $signed(DEV_W'(v_sample_reg)) - $signed(DEV_W'(center_reg));
        dev_h  = $signed(DEV_W'(h_sample_reg)) - $signed(DEV_W'(center_reg));
        mag_v  = dev_v[DEV_W-1] ? -dev_v : dev_v;
        mag_h  = dev_h[DEV_W-1] ? -dev_h : dev_h;
        dz_pos = $signed(DEV_W'(deadzone_reg));
        dz_neg = -dz_pos;
        dir    = jdbe_pkg::EV_NONE;
        if (mag_h > mag_v) begin
            if (dev_h > dz_pos) begin
                dir = jdbe_pkg::EV_RIGHT;
            end else if (dev_h < dz_neg) begin
                dir = jdbe_pkg::EV_LEFT;
            end
        end else begin
            // vertical wins ties
            if (dev_v > dz_pos) begin
                dir = jdbe_pkg::EV_DOWN;
            end else if (dev_v < dz_neg) begin
                dir = jdbe_pkg::EV_UP;
            end
        end
    end

    // ---------------- state ----------------
    jdbe_pkg::event_t     last_dir_reg, last_dir_next;
    logic [TIME_BITS-1:0] dir_time_reg, dir_time_next;
    logic                 stable_reg, stable_next;
    logic                 prev_level_reg, prev_level_next;
    logic [TIME_BITS-1:0] change_time_reg, change_time_next;
    logic [TIME_BITS-1:0] press_time_reg, press_time_next;
    logic                 long_rep_reg, long_rep_next;
    jdbe_pkg::event_t     out_event_reg, out_event_next;

    // wrapped time differences against the held timestamps
    logic [TIME_BITS-1:0] el_dir, el_change, el_press;
    logic                 repeat_due, debounce_ok, long_due;

    assign el_dir      = now_reg - dir_time_reg;
    assign el_change   = now_reg - change_time_reg;
    assign el_press    = now_reg - press_time_reg;
    assign repeat_due  = el_dir > TIME_BITS'(repeat_reg);
    // a level change in this poll restarts the debounce window at zero
    assign debounce_ok = (button_reg == prev_level_reg) &&
                         (el_change > TIME_BITS'(debounce_reg));
    assign long_due    = el_press > TIME_BITS'(long_press_reg);

    always_comb begin
        last_dir_next    = last_dir_reg;
        dir_time_next    = dir_time_reg;
        stable_next      = stable_reg;
        prev_level_next  = prev_level_reg;
        change_time_next = change_time_reg;
        press_time_next  = press_time_reg;
        long_rep_next    = long_rep_reg;
        out_event_next   = jdbe_pkg::EV_NONE;

        if (!stick_disabled_reg) begin
            if (dir != last_dir_reg) begin
                last_dir_next = dir;
                dir_time_next = now_reg;
            end
            if (dir != jdbe_pkg::EV_NONE &&
                (dir != last_dir_reg || repeat_due)) begin
                // new or repeated direction; button is skipped this poll
                dir_time_next  = now_reg;
                out_event_next = dir;
            end else begin
                if (button_reg != prev_level_reg) begin
                    change_time_next = now_reg;
                    prev_level_next  = button_reg;
                end
                if (debounce_ok && button_reg != stable_reg) begin
                    stable_next = button_reg;
                    if (!button_reg) begin
                        press_time_next = now_reg;
                        long_rep_next   = 1'b0;
                    end else if (!long_rep_reg) begin
                        out_event_next = jdbe_pkg::EV_SHORT;
                    end
                end else if (!stable_reg && !long_rep_reg && long_due) begin
                    long_rep_next  = 1'b1;
                    out_event_next = jdbe_pkg::EV_LONG;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_dir_reg    <= jdbe_pkg::EV_NONE;
            dir_time_reg    <= '0;
            stable_reg      <= 1'b1;
            prev_level_reg  <= 1'b1;
            change_time_reg <= '0;
            press_time_reg  <= '0;
            long_rep_reg    <= 1'b0;
        end else if (advance) begin
            last_dir_reg    <= last_dir_next;
            dir_time_reg    <= dir_time_next;
            stable_reg      <= stable_next;
            prev_level_reg  <= prev_level_next;
            change_time_reg <= change_time_next;
            press_time_reg  <= press_time_next;
            long_rep_reg    <= long_rep_next;
        end
    end

    // result register (payload, no reset needed)
    always_ff @(posedge aclk) begin
        if (advance) begin
            out_event_reg <= out_event_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(8-jdbe_pkg::EVENT_W){1'b0}}, out_event_reg};

    // ---------------- assertions ----------------
    // decoded result register for the checks below
    logic none_out, long_out, dir_out;

    assign none_out = (out_event_reg == jdbe_pkg::EV_NONE);
    assign long_out = out_valid_reg && (out_event_reg == jdbe_pkg::EV_LONG);
    assign dir_out  = out_valid_reg && ((out_event_reg == jdbe_pkg::EV_UP) ||
                                        (out_event_reg == jdbe_pkg::EV_DOWN) ||
                                        (out_event_reg == jdbe_pkg::EV_LEFT) ||
                                        (out_event_reg == jdbe_pkg::EV_RIGHT));

`include "joystick_direction_button_events_assert.svh"

    `JDBE_ASSERT_NEXT(a_disabled_none, advance && stick_disabled_reg, none_out, "disabled event")
    `JDBE_ASSERT_NOW(a_long_flag_event, $rose(long_rep_reg), long_out, "long flag, no event")
    `JDBE_ASSERT_NOW(a_dir_held, dir_out, last_dir_reg == out_event_reg, "direction mismatch")
    `JDBE_ASSERT_NOW(a_ready_when_empty, !out_valid_reg, s_tready, "stalled while empty")

endmodule

// ----- dv/tb_joystick_direction_button_events.sv -----
// Self-checking testbench for joystick_direction_button_events: streams polls,
// predicts each event code and compares it with what comes out of m_tdata.
// Depends on hdl/jdbe_pkg.sv and the RTL of the block.
module tb_joystick_direction_button_events;

    localparam int SAMPLE_W    = jdbe_pkg::SAMPLE_BITS_DEF;
    localparam int STAMP_W     = jdbe_pkg::TIME_BITS_DEF;
    localparam int POLL_W      = ((2*SAMPLE_W + 1 + STAMP_W + 7) / 8) * 8;
    localparam int SAMPLE_MAX  = (1 << SAMPLE_W) - 1;
    localparam int DRAIN_WAIT  = 8;        // settle time after the last owed event is out
    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_AT     = 150;      // polls taken before the long m_tready stall
    localparam int HOLD_LEN    = 300;
    localparam int SHOW_MAX    = 10;

    // One poll as it sits on s_tdata
    typedef struct packed {
        logic [STAMP_W-1:0]  now_ms;
        logic                button_pin;
        logic [SAMPLE_W-1:0] horz_code;
        logic [SAMPLE_W-1:0] vert_code;
    } poll_t;

    // How the result side paces m_tready
    typedef enum logic [1:0] {
        RX_STEADY,
        RX_COIN,
        RX_SPARSE,
        RX_COMB
    } rx_style_t;

    logic                            aclk      = 1'b0;
    logic                            aresetn   = 1'b0;
    logic                            s_tvalid  = 1'b0;
    logic                            s_tready;
    // [11:0] vertical_sample, [23:12] horizontal_sample, [24] button_level,
    // [56:25] now_ms, [63:57] zero
    logic [POLL_W-1:0]               s_tdata   = '0;
    logic                            m_tvalid;
    logic                            m_tready  = 1'b0;
    // [2:0] event_code, [7:3] zero
    logic [7:0]                      m_tdata;
    logic                            cfg_wr_en = 1'b0;
    logic [jdbe_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [jdbe_pkg::CFG_DATA_W-1:0] cfg_data  = '0;

    // Register copies, kept in step with the writes on the cfg port
    logic                          stick_off    = 1'b0;
    logic [jdbe_pkg::CENTER_W-1:0] center_cfg   = jdbe_pkg::CENTER_RST;
    logic [jdbe_pkg::DZ_W-1:0]     deadzone_cfg = jdbe_pkg::DEADZONE_RST;
    logic [jdbe_pkg::MS_W-1:0]     repeat_cfg   = jdbe_pkg::REPEAT_RST;
    logic [jdbe_pkg::MS_W-1:0]     debounce_cfg = jdbe_pkg::DEBOUNCE_RST;
    logic [jdbe_pkg::MS_W-1:0]     long_cfg     = jdbe_pkg::LONG_RST;

    // Predicted state of the stick and the button
    jdbe_pkg::event_t   held_dir       = jdbe_pkg::EV_NONE;
    logic [STAMP_W-1:0] dir_stamp      = '0;
    logic               btn_stable     = 1'b1;
    logic               btn_prev       = 1'b1;
    logic [STAMP_W-1:0] btn_edge_stamp = '0;
    logic [STAMP_W-1:0] press_stamp    = '0;
    logic               long_sent      = 1'b0;

    poll_t            polls_to_send[$];
    jdbe_pkg::event_t events_due[$];
    poll_t            poll_on_bus;
    int               polls_taken    = 0;
    int               mismatch_count = 0;
    int               cycle_count    = 0;
    int               burst_left     = 0;
    int               gap_left       = 0;
    int               hold_left      = 0;
    logic             hold_done      = 1'b0;
    int               rx_count       = 0;
    rx_style_t        rx_style       = RX_STEADY;

    joystick_direction_button_events dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 aclk = ~aclk;

    // Event the block owes for one poll; advances the predicted state.
    function automatic jdbe_pkg::event_t event_for_poll(poll_t p);
        int               dv, dh, dz, mag_v, mag_h;
        jdbe_pkg::event_t dir;
        dir = jdbe_pkg::EV_NONE;
        if (stick_off) begin
            return jdbe_pkg::EV_NONE;    // disabled: nothing reported, nothing moves
        end
        dv = int'(p.vert_code) - int'(center_cfg);
        dh = int'(p.horz_code) - int'(center_cfg);
        dz = int'(deadzone_cfg);
        mag_v = (dv < 0) ? -dv : dv;
        mag_h = (dh < 0) ? -dh : dh;
        // larger deviation wins, vertical takes a tie; deadzone is strict
        if (mag_h > mag_v) begin
            if (dh > dz) begin
                dir = jdbe_pkg::EV_RIGHT;
            end else if (dh < -dz) begin
                dir = jdbe_pkg::EV_LEFT;
            end
        end else begin
            if (dv > dz) begin
                dir = jdbe_pkg::EV_DOWN;
            end else if (dv < -dz) begin
                dir = jdbe_pkg::EV_UP;
            end
        end
        // new direction reports at once; back to centre only restamps
        if (dir != held_dir) begin
            held_dir  = dir;
            dir_stamp = p.now_ms;
            if (dir != jdbe_pkg::EV_NONE) begin
                return dir;
            end
        end
        if (dir != jdbe_pkg::EV_NONE && (p.now_ms - dir_stamp) > repeat_cfg) begin
            dir_stamp = p.now_ms;
            return dir;
        end
        // button: a direction event above skips all of this
        if (p.button_pin != btn_prev) begin
            btn_edge_stamp = p.now_ms;
            btn_prev       = p.button_pin;
        end
        if ((p.now_ms - btn_edge_stamp) > debounce_cfg && p.button_pin != btn_stable) begin
            btn_stable = p.button_pin;
            if (!btn_stable) begin
                press_stamp = p.now_ms;
                long_sent   = 1'b0;
            end else if (!long_sent) begin
                return jdbe_pkg::EV_SHORT;
            end
        end
        if (!btn_stable && !long_sent && (p.now_ms - press_stamp) > long_cfg) begin
            long_sent = 1'b1;
            return jdbe_pkg::EV_LONG;
        end
        return jdbe_pkg::EV_NONE;
    endfunction

    task automatic add_poll(int vert, int horz, int pin, logic [STAMP_W-1:0] stamp);
        poll_t p;
        p.vert_code  = vert[SAMPLE_W-1:0];
        p.horz_code  = horz[SAMPLE_W-1:0];
        p.button_pin = pin[0];
        p.now_ms     = stamp;
        polls_to_send.push_back(p);
    endtask

    // Axis code near the interesting points of the current centre/deadzone
    function automatic logic [SAMPLE_W-1:0] pick_sample();
        int c, d, s;
        c = int'(center_cfg);
        d = int'(deadzone_cfg);
        case ($urandom_range(0, 9))
            4:       s = c + d;
            5:       s = c + d + 1;
            6:       s = c - d;
            7:       s = c - d - 1;
            8:       s = $urandom_range(0, SAMPLE_MAX);
            9:       s = $urandom_range(0, 1) ? SAMPLE_MAX : 0;
            default: s = c;       // resting, lets the button through
        endcase
        if (s < 0) begin
            s = 0;
        end else if (s > SAMPLE_MAX) begin
            s = SAMPLE_MAX;
        end
        return s[SAMPLE_W-1:0];
    endfunction

    // A run of polls with held stick positions, held button levels with the
    // odd bounce, a clock that mostly steps forward, plus some pure noise.
    task automatic queue_session(int count, int unsigned step_max);
        logic [STAMP_W-1:0]  stamp;
        logic [SAMPLE_W-1:0] vert, horz;
        logic                level;
        int                  stick_run, button_run, mirrored;
        poll_t               p;
        logic [63:0]         noise;
        stamp      = $urandom;
        level      = 1'b1;
        stick_run  = 0;
        button_run = $urandom_range(1, 10);
        vert       = center_cfg;
        horz       = center_cfg;
        repeat (count) begin
            if (stick_run == 0) begin
                vert      = pick_sample();
                horz      = pick_sample();
                stick_run = $urandom_range(1, 12);
                if ($urandom_range(0, 5) == 0) begin
                    // equal deviations: vertical must win
                    mirrored = 2 * int'(center_cfg) - int'(vert);
                    if (mirrored >= 0 && mirrored <= SAMPLE_MAX && $urandom_range(0, 1)) begin
                        horz = mirrored[SAMPLE_W-1:0];
                    end else begin
                        horz = vert;
                    end
                end
            end
            stick_run--;
            if (button_run == 0) begin
                level      = ~level;
                button_run = $urandom_range(1, 40);
            end
            button_run--;
            case ($urandom_range(0, 24))
                0:       stamp = stamp - $urandom_range(0, step_max);  // clock steps back
                1:       stamp = stamp + $urandom;                     // long silence
                default: stamp = stamp + $urandom_range(0, step_max);
            endcase
            p.vert_code  = vert;
            p.horz_code  = horz;
            p.button_pin = ($urandom_range(0, 9) == 0) ? ~level : level;
            p.now_ms     = stamp;
            if ($urandom_range(0, 9) == 0) begin
                noise = {$urandom, $urandom};
                p     = noise[$bits(poll_t)-1:0];
            end
            polls_to_send.push_back(p);
        end
    endtask

    task automatic write_reg(jdbe_pkg::cfg_index_t idx,
                             logic [jdbe_pkg::CFG_DATA_W-1:0] value);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
    endtask

    // Only called with the block idle
    task automatic set_config(logic off, logic [jdbe_pkg::CENTER_W-1:0] center,
                              logic [jdbe_pkg::DZ_W-1:0] dz,
                              logic [jdbe_pkg::MS_W-1:0] rep,
                              logic [jdbe_pkg::MS_W-1:0] deb,
                              logic [jdbe_pkg::MS_W-1:0] lp);
        write_reg(jdbe_pkg::CFG_STICK_DISABLED, {{(jdbe_pkg::CFG_DATA_W-1){1'b0}}, off});
        write_reg(jdbe_pkg::CFG_CENTER_VALUE,
                  {{(jdbe_pkg::CFG_DATA_W-jdbe_pkg::CENTER_W){1'b0}}, center});
        write_reg(jdbe_pkg::CFG_DEADZONE,
                  {{(jdbe_pkg::CFG_DATA_W-jdbe_pkg::DZ_W){1'b0}}, dz});
        write_reg(jdbe_pkg::CFG_REPEAT_MS, rep);
        write_reg(jdbe_pkg::CFG_DEBOUNCE_MS, deb);
        write_reg(jdbe_pkg::CFG_LONG_PRESS_MS, lp);
        @(posedge aclk);
        cfg_wr_en    <= 1'b0;
        stick_off    = off;
        center_cfg   = center;
        deadzone_cfg = dz;
        repeat_cfg   = rep;
        debounce_cfg = deb;
        long_cfg     = lp;
    endtask

    // Sender stays quiet until every owed event is out; sampled mid-cycle
    task automatic wait_idle();
        do begin
            @(negedge aclk);
        end while (polls_to_send.size() != 0 || s_tvalid || events_due.size() != 0);
        repeat (DRAIN_WAIT) @(posedge aclk);
    endtask

    task automatic log_mismatch(string what, int want, int got);
        mismatch_count++;
        if (mismatch_count <= SHOW_MAX) begin
            $display("[%0d] %s: expected event %0d, got %0d", cycle_count, what, want, got);
        end
    endtask

    // Stimulus: directed polls at reset settings, then random sessions
    // under a series of register settings, extremes included.
    initial begin : stimulus
        int unsigned deb, lp;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        add_poll(1800, 1800, 1, 0);             // resting, nothing
        add_poll(0, 1800, 1, 10);               // up
        add_poll(0, 1800, 1, 20);               // held inside the repeat window
        add_poll(0, 1800, 1, 261);              // repeat fires
        add_poll(1800, 4095, 1, 270);           // right
        add_poll(3600, 0, 1, 280);              // equal deviations: vertical wins, down
        add_poll(2500, 1800, 1, 290);           // exactly on the deadzone: silent centre
        add_poll(2501, 1800, 1, 300);           // one past: down
        add_poll(1800, 1099, 1, 310);           // left
        add_poll(1800, 1100, 1, 320);           // on the edge again: centre
        add_poll(1800, 1800, 0, 400);           // press edge
        add_poll(1800, 1800, 0, 430);           // exactly debounce: not yet stable
        add_poll(1800, 1800, 0, 431);           // debounced press
        add_poll(1800, 1800, 1, 450);
        add_poll(1800, 1800, 1, 481);           // short press on release
        add_poll(1800, 1800, 0, 500);
        add_poll(1800, 1800, 0, 531);
        add_poll(1800, 1800, 0, 1032);          // long press while held
        add_poll(1800, 1800, 1, 1100);
        add_poll(1800, 1800, 1, 1131);          // release after long press: nothing
        add_poll(0, 4095, 0, 1140);             // right wins; button not looked at
        add_poll(1800, 1800, 0, 1150);          // silent centre, button edge seen now
        add_poll(1800, 1800, 0, 100);           // clock went back: wrapped gap debounces
        add_poll(1800, 1800, 0, 90);            // back again: wrapped gap gives long press
        add_poll(4095, 1800, 1, 32'hFFFF_FFFF); // down at the top timestamp
        add_poll(4095, 0, 1, 32'd5);            // held across the wrap, no repeat
        queue_session(120, 40);
        wait_idle();

        set_config(1'b0, '0, '0, '0, '0, '0);
        queue_session(100, 5);
        wait_idle();

        set_config(1'b0, 12'hFFF, 12'hFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        queue_session(60, 20000);
        wait_idle();

        set_config(1'b0, 12'hFFF, 12'd300, 16'hFFFF, 16'd0, 16'hFFFF);
        queue_session(60, 20000);
        wait_idle();

        // disabled: every poll answers none and state holds
        set_config(1'b1, 12'd0, 12'd0, 16'd0, 16'd0, 16'd0);
        queue_session(60, 40);
        wait_idle();

        repeat (3) begin
            deb = $urandom_range(0, 800);
            lp  = $urandom_range(0, 800);
            set_config(1'b0, jdbe_pkg::CENTER_W'($urandom_range(0, SAMPLE_MAX)),
                       jdbe_pkg::DZ_W'($urandom_range(0, 1500)),
                       jdbe_pkg::MS_W'($urandom_range(0, 800)),
                       jdbe_pkg::MS_W'(deb), jdbe_pkg::MS_W'(lp));
            queue_session(80, (deb + lp) / 10 + 5);
            wait_idle();
        end

        set_config(1'b0, jdbe_pkg::CENTER_RST, jdbe_pkg::DEADZONE_RST,
                   jdbe_pkg::REPEAT_RST, jdbe_pkg::DEBOUNCE_RST, jdbe_pkg::LONG_RST);
        queue_session(100, 40);
        wait_idle();

        if (mismatch_count == 0 && events_due.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    // Poll driver: bursts of random length with random gaps; a taken poll
    // is predicted right at its handshake.
    always @(posedge aclk) begin : poll_driver
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
        end else begin
            if (s_tvalid && s_tready) begin
                events_due.push_back(event_for_poll(poll_on_bus));
                polls_taken <= polls_taken + 1;
            end
            if (!s_tvalid || s_tready) begin
                if (gap_left != 0 || polls_to_send.size() == 0) begin
                    if (gap_left != 0) begin
                        gap_left--;
                    end
                    s_tvalid <= 1'b0;
                end else begin
                    poll_on_bus = polls_to_send.pop_front();
                    s_tdata  <= {{(POLL_W - $bits(poll_t)){1'b0}}, poll_on_bus};
                    s_tvalid <= 1'b1;
                    if (burst_left <= 1) begin
                        burst_left = $urandom_range(1, 24);
                        // a quarter of bursts run straight into the next one
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                    end else begin
                        burst_left--;
                    end
                end
            end
        end
    end

    // One long m_tready hold-off while polls keep coming, so the block
    // fills and has to drop s_tready.
    always @(posedge aclk) begin : result_hold
        if (!aresetn) begin
            hold_left <= 0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if (!hold_done && polls_taken >= HOLD_AT) begin
            hold_left <= HOLD_LEN;
            hold_done <= 1'b1;
        end
    end

    // Result monitor: checks each transaction against the oldest owed event
    // and paces m_tready in a randomly chosen style.
    always @(posedge aclk) begin : result_monitor
        jdbe_pkg::event_t want;
        logic             ready_now;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (events_due.size() == 0) begin
                    log_mismatch("event with none owed", -1,
                                 m_tdata[jdbe_pkg::EVENT_W-1:0]);
                end else begin
                    want = events_due.pop_front();
                    if (m_tdata[jdbe_pkg::EVENT_W-1:0] !== want) begin
                        log_mismatch("event_code", want, m_tdata[jdbe_pkg::EVENT_W-1:0]);
                    end
                end
            end
            rx_count++;
            if (rx_count % 64 == 0) begin
                rx_style = rx_style_t'($urandom_range(0, 3));
            end
            case (rx_style)
                RX_COIN:   ready_now = $urandom_range(0, 1);
                RX_SPARSE: ready_now = ($urandom_range(0, 3) == 0);
                RX_COMB:   ready_now = (rx_count % 4 != 3);
                default:   ready_now = 1'b1;
            endcase
            m_tready <= ready_now && (hold_left == 0);
        end
    end

    always @(posedge aclk) begin : watchdog
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

endmodule

// ----- filelist.f -----
+incdir+hdl
hdl/jdbe_pkg.sv
hdl/joystick_direction_button_events.sv
dv/tb_joystick_direction_button_events.sv
